/* hdl/aarm_pkg.sv */
// Package with the constants, types and helpers of the axis-angle rotation matrix unit.
`timescale 1ns / 1ps
package aarm_pkg;

  localparam int CORDIC_STEPS  = 14;
  localparam int FRACTION_BITS = 14;
  localparam int ATAN_ENTRIES  = 24;
  localparam int STEPS = (CORDIC_STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STEPS;
  // Working word: three integer bits, sign, fraction, one guard bit for the CORDIC growth.
  localparam int WW = FRACTION_BITS + 5;
  localparam int SW = (STEPS > 1) ? $clog2(STEPS) : 1;

  localparam longint Q30_PI      = 64'sd3373259426;
  localparam longint Q30_HALF_PI = 64'sd1686629713;
  localparam longint Q30_GAIN    = 64'sd652032874;

  typedef logic signed [WW-1:0] work_t;
  typedef logic signed [15:0]   q14_t;

  // Rounds a non-negative Q30 constant to the working fraction, half up.
  function automatic work_t q30_to_work(input longint t);
    longint r;
    if (FRACTION_BITS >= 30) r = t <<< (FRACTION_BITS - 30);
    else r = (t + (64'sd1 <<< (29 - FRACTION_BITS))) >>> (30 - FRACTION_BITS);
    return work_t'(r);
  endfunction

  function automatic work_t atan_work(input int i);
    longint t;
    case (i)
      0: t = 843314856;   1: t = 497837829;   2: t = 263043836;   3: t = 133525158;
      4: t = 66987894;    5: t = 33542491;    6: t = 16776874;    7: t = 8388437;
      8: t = 4194282;     9: t = 2097149;     10: t = 1048575;    11: t = 524287;
      12: t = 262143;     13: t = 131071;     14: t = 65535;      15: t = 32767;
      16: t = 16383;      17: t = 8191;       18: t = 4095;       19: t = 2047;
      20: t = 1023;       21: t = 511;        22: t = 255;        default: t = 127;
    endcase
    return q30_to_work(t);
  endfunction

  // One word of the CORDIC pipeline.
  typedef struct packed {
    logic  vld;
    logic  flip;
    work_t x;
    work_t y;
    work_t z;
    q14_t  ax;
    q14_t  ay;
    q14_t  az;
  } cord_t;

endpackage

/* hdl/aarm_cordic.sv */
// Pipelined rotation-mode CORDIC giving cosine and sine, one stage per iteration.
`timescale 1ns / 1ps
module aarm_cordic import aarm_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  cord_t in_word,
  output cord_t out_word
);

  cord_t stage_r [STEPS+1];
  cord_t stage_nxt [STEPS+1];

  // Quadrant fold at stage entry.
  always_comb begin
    work_t zin;
    stage_nxt[0] = in_word;
    zin = in_word.z;
    stage_nxt[0].flip = 1'b0;
    stage_nxt[0].x = q30_to_work(Q30_GAIN);
    stage_nxt[0].y = '0;
    if (zin > q30_to_work(Q30_HALF_PI)) begin
      stage_nxt[0].z = zin - q30_to_work(Q30_PI);
      stage_nxt[0].flip = 1'b1;
    end else if (zin < -q30_to_work(Q30_HALF_PI)) begin
      stage_nxt[0].z = zin + q30_to_work(Q30_PI);
      stage_nxt[0].flip = 1'b1;
    end
  end

  // One micro-rotation per stage.
  for (genvar i = 0; i < STEPS; i++) begin : g_step
    always_comb begin
      work_t dx;
      work_t dy;
      dx = stage_r[i].y >>> i;
      dy = stage_r[i].x >>> i;
      stage_nxt[i+1] = stage_r[i];
      if (!stage_r[i].z[WW-1]) begin
        stage_nxt[i+1].x = stage_r[i].x - dx;
        stage_nxt[i+1].y = stage_r[i].y + dy;
        stage_nxt[i+1].z = stage_r[i].z - atan_work(i);
      end else begin
        stage_nxt[i+1].x = stage_r[i].x + dx;
        stage_nxt[i+1].y = stage_r[i].y - dy;
        stage_nxt[i+1].z = stage_r[i].z + atan_work(i);
      end
    end
  end

  for (genvar i = 0; i <= STEPS; i++) begin : g_reg
    always_ff @(posedge clk) begin
      if (!rst_n) stage_r[i] <= '0;
      else stage_r[i] <= stage_nxt[i];
    end
  end

  // Undo the fold on the way out.
  always_comb begin
    out_word = stage_r[STEPS];
    if (stage_r[STEPS].flip) begin
      out_word.x = -stage_r[STEPS].x;
      out_word.y = -stage_r[STEPS].y;
    end
  end

endmodule

/* hdl/axis_angle_rotation_matrix_unit.sv */
// Top level of the axis-angle rotation matrix unit.
`timescale 1ns / 1ps
// A word is accepted on any cycle with start high; busy is always low, so one rotation
// can enter every clock. Each result appears on out_valid for one cycle, after its word
// has passed one fold stage, one stage per CORDIC iteration, and four stages of
// products, sums and rounding. The receiver cannot stall, and there is no backlog.
module axis_angle_rotation_matrix_unit import aarm_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] in_angle,
  input  logic [15:0] in_axis_x,
  input  logic [15:0] in_axis_y,
  input  logic [15:0] in_axis_z,
  output logic        out_valid,
  output logic [15:0] out_m00, output logic [15:0] out_m01, output logic [15:0] out_m02,
  output logic [15:0] out_m10, output logic [15:0] out_m11, output logic [15:0] out_m12,
  output logic [15:0] out_m20, output logic [15:0] out_m21, output logic [15:0] out_m22
);

  localparam int PW  = 2 * 16 + WW + 16;   // exact entry width in Q(28+F)
  localparam int SH  = 14 + FRACTION_BITS;

  cord_t cin;
  cord_t cout;

  assign busy = 1'b0;

  // Angle into the working fraction.
  always_comb begin
    logic signed [WW+16:0] ang;
    ang = (WW+17)'($signed(in_angle));
    cin = '0;
    cin.vld = start;
    if (FRACTION_BITS >= 13) cin.z = work_t'(ang <<< (FRACTION_BITS - 13));
    else cin.z = work_t'((ang + ((WW+17)'(1) <<< (12 - FRACTION_BITS))) >>> (13 - FRACTION_BITS));
    cin.ax = $signed(in_axis_x);
    cin.ay = $signed(in_axis_y);
    cin.az = $signed(in_axis_z);
  end

  aarm_cordic u_cordic (.clk(clk), .rst_n(rst_n), .in_word(cin), .out_word(cout));

  // Stage A: axis products, omc, and cosine, sine and axis copies.
  logic                 a_vld_r;
  logic signed [31:0]   pxx_r, pxy_r, pxz_r, pyy_r, pyz_r, pzz_r;
  logic signed [WW:0]   omc_r, c_r, s_r;
  q14_t                 ax_r, ay_r, az_r;

  always_ff @(posedge clk) begin
    a_vld_r <= rst_n & cout.vld;
    pxx_r <= cout.ax * cout.ax; pxy_r <= cout.ax * cout.ay; pxz_r <= cout.ax * cout.az;
    pyy_r <= cout.ay * cout.ay; pyz_r <= cout.ay * cout.az; pzz_r <= cout.az * cout.az;
    omc_r <= (WW+1)'(64'sd1 <<< FRACTION_BITS) - (WW+1)'(cout.x);
    c_r <= (WW+1)'(cout.x);
    s_r <= (WW+1)'(cout.y);
    ax_r <= cout.ax; ay_r <= cout.ay; az_r <= cout.az;
  end

  // Stage B: products with omc and sine, and the shifted cosine, operands widened to the full entry width.
  logic                 b_vld_r;
  logic signed [PW-1:0] qxx_r, qxy_r, qxz_r, qyy_r, qyz_r, qzz_r, cd_r, xs_r, ys_r, zs_r;

  always_ff @(posedge clk) begin
    b_vld_r <= rst_n & a_vld_r;
    qxx_r <= PW'(pxx_r) * PW'(omc_r); qxy_r <= PW'(pxy_r) * PW'(omc_r);
    qxz_r <= PW'(pxz_r) * PW'(omc_r); qyy_r <= PW'(pyy_r) * PW'(omc_r);
    qyz_r <= PW'(pyz_r) * PW'(omc_r); qzz_r <= PW'(pzz_r) * PW'(omc_r);
    cd_r <= PW'(c_r) <<< 28;
    xs_r <= (PW'(ax_r) * PW'(s_r)) <<< 14;
    ys_r <= (PW'(ay_r) * PW'(s_r)) <<< 14;
    zs_r <= (PW'(az_r) * PW'(s_r)) <<< 14;
  end

  // Stage C: sums.
  logic                 c_vld_r;
  logic signed [PW-1:0] e_r [9];

  always_ff @(posedge clk) begin
    c_vld_r <= rst_n & b_vld_r;
    e_r[0] <= qxx_r + cd_r; e_r[1] <= qxy_r - zs_r; e_r[2] <= qxz_r + ys_r;
    e_r[3] <= qxy_r + zs_r; e_r[4] <= qyy_r + cd_r; e_r[5] <= qyz_r - xs_r;
    e_r[6] <= qxz_r - ys_r; e_r[7] <= qyz_r + xs_r; e_r[8] <= qzz_r + cd_r;
  end

  // Stage D: round half up and saturate.
  logic                 d_vld_r;
  q14_t                 m_r [9];

  for (genvar k = 0; k < 9; k++) begin : g_fin
    logic signed [PW:0] rnd;
    assign rnd = ((PW+1)'(e_r[k]) + ((PW+1)'(1) <<< (SH - 1))) >>> SH;
    always_ff @(posedge clk) begin
      if (rnd > 32767) m_r[k] <= 16'sd32767;
      else if (rnd < -32768) m_r[k] <= -16'sd32768;
      else m_r[k] <= q14_t'(rnd);
    end
  end

  always_ff @(posedge clk) d_vld_r <= rst_n & c_vld_r;

  assign out_valid = d_vld_r;
  assign out_m00 = m_r[0]; assign out_m01 = m_r[1]; assign out_m02 = m_r[2];
  assign out_m10 = m_r[3]; assign out_m11 = m_r[4]; assign out_m12 = m_r[5];
  assign out_m20 = m_r[6]; assign out_m21 = m_r[7]; assign out_m22 = m_r[8];

  // The product stages carry every word on to the output strobe.
  a_chain: assert property (@(posedge clk) disable iff (!rst_n) a_vld_r |=> b_vld_r)
    else $error("valid lost between product stages");
  c_chain: assert property (@(posedge clk) disable iff (!rst_n) c_vld_r |=> out_valid)
    else $error("valid lost before output");
  no_busy: assert property (@(posedge clk) !busy)
    else $error("busy raised");

endmodule

/* tb/sv/axis_angle_rotation_matrix_unit_tb.sv */
// Testbench that checks the rotation matrix unit against its own fixed-point predictor.
`timescale 1ns / 1ps
module axis_angle_rotation_matrix_unit_tb;
  import aarm_pkg::*;

  localparam int LATENCY     = CORDIC_STEPS + 5;
  localparam int N_RANDOM    = 1750;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct {
    logic [15:0] angle;
    logic [15:0] ax;
    logic [15:0] ay;
    logic [15:0] az;
  } rot_req_t;

  typedef struct {
    logic [15:0] m [9];
  } matrix_t;

  // One directed row; has_fixed marks rows whose matrix is typed in.
  typedef struct {
    rot_req_t req;
    bit       has_fixed;
    matrix_t  fixed;
  } dir_row_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [15:0] in_angle, in_axis_x, in_axis_y, in_axis_z;
  logic        out_valid;
  logic [15:0] out_m00, out_m01, out_m02, out_m10, out_m11, out_m12;
  logic [15:0] out_m20, out_m21, out_m22;

  matrix_t matrix_queue[$];
  int      fail_count;
  int      cycle_count;

  axis_angle_rotation_matrix_unit uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_angle(in_angle), .in_axis_x(in_axis_x), .in_axis_y(in_axis_y),
    .in_axis_z(in_axis_z), .out_valid(out_valid),
    .out_m00(out_m00), .out_m01(out_m01), .out_m02(out_m02),
    .out_m10(out_m10), .out_m11(out_m11), .out_m12(out_m12),
    .out_m20(out_m20), .out_m21(out_m21), .out_m22(out_m22)
  );

  // Clock with a 12 ns period.
  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  function automatic longint floor_shift(input longint v, input int k);
    if (k > 62) return (v < 0) ? -1 : 0;
    return v >>> k;
  endfunction

  // Non-negative Q30 constant rounded half up to the working fraction.
  function automatic longint q30_round(input longint t);
    if (FRACTION_BITS >= 30) return t <<< (FRACTION_BITS - 30);
    return floor_shift(t + (64'sd1 <<< (29 - FRACTION_BITS)), 30 - FRACTION_BITS);
  endfunction

  function automatic longint arctan_q30(input int i);
    longint tbl [24] = '{843314856, 497837829, 263043836, 133525158, 66987894,
                         33542491, 16776874, 8388437, 4194282, 2097149, 1048575,
                         524287, 262143, 131071, 65535, 32767, 16383, 8191,
                         4095, 2047, 1023, 511, 255, 127};
    return tbl[i];
  endfunction

  // Product sum in Q(28+F) rounded to Q1.14 and saturated.
  function automatic logic [15:0] round_saturate(input longint acc);
    longint r;
    r = floor_shift(acc + (64'sd1 <<< (13 + FRACTION_BITS)), 14 + FRACTION_BITS);
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[15:0];
  endfunction

  // Cosine and sine by folded rotation-mode CORDIC, then the Rodrigues matrix.
  function automatic matrix_t rotation_matrix(input rot_req_t rq);
    matrix_t res;
    longint ang, x, y, dx, dy, a, pi_w, half_pi_w, c, s, omc, cdiag, xs, ys, zs;
    longint vx, vy, vz;
    bit flip;
    int n;
    ang = longint'($signed(rq.angle));
    vx = longint'($signed(rq.ax));
    vy = longint'($signed(rq.ay));
    vz = longint'($signed(rq.az));
    if (FRACTION_BITS >= 13) ang = ang <<< (FRACTION_BITS - 13);
    else ang = floor_shift(ang + (64'sd1 <<< (12 - FRACTION_BITS)), 13 - FRACTION_BITS);
    pi_w = q30_round(Q30_PI);
    half_pi_w = q30_round(Q30_HALF_PI);
    flip = 1'b0;
    if (ang > half_pi_w) begin
      ang -= pi_w;
      flip = 1'b1;
    end else if (ang < -half_pi_w) begin
      ang += pi_w;
      flip = 1'b1;
    end
    x = q30_round(Q30_GAIN);
    y = 0;
    n = (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;
    for (int i = 0; i < n; i++) begin
      dx = floor_shift(y, i);
      dy = floor_shift(x, i);
      a = q30_round(arctan_q30(i));
      if (ang >= 0) begin
        x -= dx;
        y += dy;
        ang -= a;
      end else begin
        x += dx;
        y -= dy;
        ang += a;
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
    omc = (64'sd1 <<< FRACTION_BITS) - c;
    cdiag = c <<< 28;
    xs = vx * s * 16384;
    ys = vy * s * 16384;
    zs = vz * s * 16384;
    res.m[0] = round_saturate(vx * vx * omc + cdiag);
    res.m[1] = round_saturate(vx * vy * omc - zs);
    res.m[2] = round_saturate(vx * vz * omc + ys);
    res.m[3] = round_saturate(vy * vx * omc + zs);
    res.m[4] = round_saturate(vy * vy * omc + cdiag);
    res.m[5] = round_saturate(vy * vz * omc - xs);
    res.m[6] = round_saturate(vx * vz * omc - ys);
    res.m[7] = round_saturate(vy * vz * omc + xs);
    res.m[8] = round_saturate(vz * vz * omc + cdiag);
    return res;
  endfunction

  function automatic rot_req_t make_req(input int ang, input int x, input int y, input int z);
    rot_req_t r;
    r.angle = 16'(ang);
    r.ax = 16'(x);
    r.ay = 16'(y);
    r.az = 16'(z);
    return r;
  endfunction

  // Random request: mostly angles within +-pi and axis components within +-1.0, some full-range noise.
  function automatic rot_req_t random_req();
    rot_req_t r;
    int sel;
    sel = $urandom_range(0, 9);
    r.angle = (sel == 0) ? 16'($urandom) : 16'($urandom_range(0, 51472) - 25736);
    if (sel < 3) begin
      r.ax = 16'($urandom);
      r.ay = 16'($urandom);
      r.az = 16'($urandom);
    end else begin
      r.ax = 16'($urandom_range(0, 32768) - 16384);
      r.ay = 16'($urandom_range(0, 32768) - 16384);
      r.az = 16'($urandom_range(0, 32768) - 16384);
    end
    return r;
  endfunction

  // Send one word and leave start high; the caller drops it for a gap.
  task automatic send_word(input rot_req_t r);
    start <= 1'b1;
    in_angle <= r.angle;
    in_axis_x <= r.ax;
    in_axis_y <= r.ay;
    in_axis_z <= r.az;
    do @(posedge clk); while (busy);
    matrix_queue.push_back(rotation_matrix(r));
  endtask

  // Compare each result word against the oldest prediction.
  always @(posedge clk) begin
    matrix_t exp_m;
    logic [15:0] got [9];
    if (rst_n && out_valid) begin
      got = '{out_m00, out_m01, out_m02, out_m10, out_m11, out_m12,
              out_m20, out_m21, out_m22};
      if (matrix_queue.size() == 0) begin
        $error("result word with no prediction waiting");
        fail_count++;
      end else begin
        exp_m = matrix_queue.pop_front();
        for (int k = 0; k < 9; k++) begin
          if (got[k] !== exp_m.m[k]) begin
            $error("m%0d%0d expected %h actual %h", k / 3, k % 3, exp_m.m[k], got[k]);
            fail_count++;
          end
        end
      end
    end
  end

  // Cycle limit guard.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("axis_angle_rotation_matrix_unit: mismatch");
      $finish;
    end
  end

  initial begin
    dir_row_t rows[$];
    dir_row_t row;
    int burst, gap, sent, wait_cycles;
    matrix_t ident;
    matrix_t chk;
    fail_count = 0;
    cycle_count = 0;
    rst_n = 1'b0;
    start = 1'b0;
    in_angle = '0;
    in_axis_x = '0;
    in_axis_y = '0;
    in_axis_z = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed rows: zero angle with zero axis gives the CORDIC cosine on the diagonal,
    // which lands one step below 1.0.
    ident.m = '{16'h3fff, 16'h0000, 16'h0000, 16'h0000, 16'h3fff, 16'h0000,
                16'h0000, 16'h0000, 16'h3fff};
    row.has_fixed = 1'b1;
    row.fixed = ident;
    row.req = make_req(0, 0, 0, 0);
    rows.push_back(row);
    row.has_fixed = 1'b0;
    rows.push_back(row);
    // Limits of pi, fold thresholds, out-of-range angles and axis extremes.
    row.req = make_req(25736, 16384, 0, 0);       rows.push_back(row);
    row.req = make_req(-25736, 0, 16384, 0);      rows.push_back(row);
    row.req = make_req(12868, 0, 0, 16384);       rows.push_back(row);
    row.req = make_req(12869, 0, 0, -16384);      rows.push_back(row);
    row.req = make_req(-12868, -16384, 0, 0);     rows.push_back(row);
    row.req = make_req(-12869, 0, -16384, 0);     rows.push_back(row);
    row.req = make_req(32767, 9459, 9459, 9459);  rows.push_back(row);
    row.req = make_req(-32768, -9459, 9459, -9459); rows.push_back(row);
    row.req = make_req(1, 11585, 11585, 0);       rows.push_back(row);
    row.req = make_req(-1, 0, 11585, -11585);     rows.push_back(row);
    // Non-unit axes that saturate.
    row.req = make_req(25736, 32767, 32767, 32767);    rows.push_back(row);
    row.req = make_req(-25736, -32768, -32768, -32768); rows.push_back(row);
    row.req = make_req(8192, 32767, -32768, 16384);    rows.push_back(row);
    row.req = make_req(-8192, 16384, 16384, 16384);    rows.push_back(row);
    row.req = make_req(6434, -16384, -16384, -16384);  rows.push_back(row);
    row.req = make_req(16'h5555, 16'h5555, 16'haaaa, 16'h5555); rows.push_back(row);
    row.req = make_req(16'haaaa, 16'haaaa, 16'h5555, 16'haaaa); rows.push_back(row);

    @(posedge clk);
    foreach (rows[i]) begin
      if (rows[i].has_fixed) begin
        chk = rotation_matrix(rows[i].req);
        if (chk.m != rows[i].fixed.m) begin
          $error("predictor disagrees with the typed-in matrix in row %0d", i);
          fail_count++;
        end
      end
      send_word(rows[i].req);
    end

    // Random bursts with random gaps, some long stretches without gaps.
    sent = 0;
    while (sent < N_RANDOM) begin
      burst = $urandom_range(1, ($urandom_range(0, 4) == 0) ? 60 : 8);
      for (int b = 0; b < burst && sent < N_RANDOM; b++) begin
        send_word(random_req());
        sent++;
      end
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    start <= 1'b0;

    // Drain the pipeline.
    wait_cycles = 0;
    while (matrix_queue.size() != 0 && wait_cycles < 20 * LATENCY) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (LATENCY + 4) @(posedge clk);
    if (matrix_queue.size() != 0) begin
      $error("%0d predicted words never arrived", matrix_queue.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("axis_angle_rotation_matrix_unit: match");
    end else begin
      $display("axis_angle_rotation_matrix_unit: mismatch");
    end
    $finish;
  end

endmodule
